// ===== rtl/fnms_pkg.sv =====
// ----------------------------------------------------------------------------
// fnms_pkg
// Shared types, constants and helpers for the file name match scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package fnms_pkg;

  localparam int MAX_PATTERN_LEN = 16;
  localparam int MAX_NAME_LEN    = 256;

  localparam int PAT_IDX_W = $clog2(MAX_PATTERN_LEN);
  localparam int PAT_LEN_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int POS_W     = $clog2(MAX_NAME_LEN + 2);
  localparam int SCORE_W   = 10;
  localparam int CHAR_W    = 8;
  localparam int ADD_W     = 6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_SLASH     = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET    = 8'h20;

  localparam logic [SCORE_W-1:0] SCORE_SUBSTRING = 10'd1000;
  localparam logic [ADD_W-1:0]   ADD_MATCH       = 6'd10;
  localparam logic [ADD_W-1:0]   ADD_CONSEC      = 6'd5;
  localparam logic [ADD_W-1:0]   ADD_BOUNDARY    = 6'd15;

  // Division by ten as (x * 205) >> 11, exact for x below 1029.
  localparam int DIV10_MUL_W = 8;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 8'd205;
  localparam int DIV10_SHIFT = 11;
  localparam int DIV10_PROD_W = POS_W + DIV10_MUL_W;

  typedef struct packed {
    logic              last_char;
    logic [CHAR_W-1:0] name_char;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] match_score;
    logic               name_too_long;
  } out_item_t;

  typedef struct packed {
    logic [MAX_PATTERN_LEN-1:0][CHAR_W-1:0] chars;
    logic [PAT_LEN_W-1:0]                   len;
  } pattern_t;

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
  endfunction

  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z);
  endfunction

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    return is_upper(c) ? c + CASE_OFFSET : c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fuzzy_name_match_scorer_top.sv =====
// ----------------------------------------------------------------------------
// fuzzy_name_match_scorer_top
// Scores a streamed file name against a configured search pattern.
// ----------------------------------------------------------------------------
// A file name enters on the in channel one byte per request, with last_char
// set on its final byte. Only the final byte produces an out request, which
// carries the score and the too-long flag; other bytes produce nothing.
// The pattern is loaded through the cfg channel (index 0 and 1 for the
// characters, index 2 for the length), which is always ready; write it only
// while no name is in flight.
// Throughput is one byte per cycle unless a final byte waits for the output.
// An accepted byte is held in the input register and is processed against
// the per-name state as it leaves; a final byte's result goes to the
// output register. The per-name state update loop sets that rate.
// If the receiver stalls, the result is held in the output register; bytes
// that produce no result keep flowing, and a further final byte waits in the
// input register, which is when in_ready_o drops.
// Reset clears the pattern to empty and all per-name state; no request is
// pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_name_match_scorer_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire fnms_pkg::in_item_t          in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output fnms_pkg::out_item_t              out_data_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [fnms_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [fnms_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic                s1_valid_q;
  fnms_pkg::in_item_t  s1_item_q;
  logic                s1_fire;
  logic                out_valid_q;
  fnms_pkg::out_item_t out_q;
  fnms_pkg::out_item_t result;
  fnms_pkg::pattern_t  pattern;

  fnms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pattern_o   (pattern)
  );

  fnms_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_fire),
    .item_i    (s1_item_q),
    .pattern_i (pattern),
    .result_o  (result)
  );

  // A final byte needs a free output slot; other bytes always move on.
  assign s1_fire    = s1_valid_q && (!s1_item_q.last_char || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire && s1_item_q.last_char) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
    if (s1_fire && s1_item_q.last_char) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/fnms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fnms_cfg_regs
// Pattern registers with write port; presents the folded, clamped pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module fnms_cfg_regs (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [fnms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [fnms_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output fnms_pkg::pattern_t                 pattern_o
);

  logic [fnms_pkg::CFG_DATA_W-1:0] pat_low_q, pat_high_q;
  logic [fnms_pkg::PAT_LEN_W-1:0]  pat_len_q;
  logic [2*fnms_pkg::CFG_DATA_W-1:0] pat_all;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fnms_pkg::CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        fnms_pkg::CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
        fnms_pkg::CFG_PAT_LEN:  pat_len_q  <= cfg_data_i[fnms_pkg::PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_high_q, pat_low_q};

  always_comb begin
    for (int k = 0; k < fnms_pkg::MAX_PATTERN_LEN; k++) begin
      pattern_o.chars[k] = fnms_pkg::fold_char(pat_all[k*fnms_pkg::CHAR_W +: fnms_pkg::CHAR_W]);
    end
    // Lengths above the maximum count as the maximum.
    if (pat_len_q > fnms_pkg::PAT_LEN_W'(fnms_pkg::MAX_PATTERN_LEN)) begin
      pattern_o.len = fnms_pkg::PAT_LEN_W'(fnms_pkg::MAX_PATTERN_LEN);
    end else begin
      pattern_o.len = pat_len_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fnms_core.sv =====
// ----------------------------------------------------------------------------
// fnms_core
// Per-name match state, its byte update and the final score.
// ----------------------------------------------------------------------------
`default_nettype none

module fnms_core (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       step_i,
  input  wire fnms_pkg::in_item_t   item_i,
  input  wire fnms_pkg::pattern_t   pattern_i,
  output fnms_pkg::out_item_t       result_o
);

  localparam int PL = fnms_pkg::MAX_PATTERN_LEN;
  localparam int CW = fnms_pkg::CHAR_W;
  localparam int PW = fnms_pkg::POS_W;
  localparam int LW = fnms_pkg::PAT_LEN_W;
  localparam int SW = fnms_pkg::SCORE_W;

  logic [PL-1:0][CW-1:0] recent_q, recent_d;
  logic [CW-1:0]         prev_raw_q, prev_raw_d;
  logic [PW-1:0]         pos_q, pos_d, pos_n;
  logic [LW-1:0]         prog_q, prog_d, prog_n;
  logic                  prev_match_q, prev_match_d;
  logic [SW-1:0]         run_q, run_d, run_n;
  logic                  sub_found_q, sub_found_d, sub_found_n;
  logic [PW-1:0]         sub_start_q, sub_start_d, sub_start_n;

  logic [CW-1:0]         raw, low;
  logic [PL-1:0][CW-1:0] window;
  logic                  take, window_full, window_eq, char_match;
  logic [LW-1:0]         ridx;
  logic [fnms_pkg::ADD_W-1:0] add;
  logic [PW:0]           pos_plus1;
  logic [fnms_pkg::DIV10_PROD_W-1:0] pen_prod;
  logic [SW-1:0]         pen, score;

  assign raw  = item_i.name_char;
  assign low  = fnms_pkg::fold_char(raw);
  assign take = pos_q < PW'(fnms_pkg::MAX_NAME_LEN);
  assign pos_plus1 = {1'b0, pos_q} + (PW+1)'(1);

  always_comb begin
    window[0] = low;
    for (int k = 1; k < PL; k++) begin
      window[k] = recent_q[k-1];
    end
  end

  // Newest byte sits at window[0] and lines up with the last pattern character.
  always_comb begin
    window_eq = 1'b1;
    ridx      = '0;
    for (int k = 0; k < PL; k++) begin
      ridx = pattern_i.len - LW'(k + 1);
      if ((LW'(k) < pattern_i.len) &&
          (window[k] != pattern_i.chars[ridx[fnms_pkg::PAT_IDX_W-1:0]])) begin
        window_eq = 1'b0;
      end
    end
  end

  assign window_full = pos_plus1 >= (PW+1)'(pattern_i.len);
  assign char_match  = (prog_q < pattern_i.len) &&
                       (low == pattern_i.chars[prog_q[fnms_pkg::PAT_IDX_W-1:0]]);

  always_comb begin
    add = fnms_pkg::ADD_MATCH;
    if ((pos_q == '0) || prev_match_q) begin
      add = add + fnms_pkg::ADD_CONSEC;
    end
    if ((pos_q != '0) &&
        ((prev_raw_q == fnms_pkg::CHAR_SLASH) || (prev_raw_q == fnms_pkg::CHAR_BACKSLASH) ||
         (fnms_pkg::is_upper(raw) && fnms_pkg::is_lower(prev_raw_q)))) begin
      add = add + fnms_pkg::ADD_BOUNDARY;
    end
  end

  // State after this byte, before the end-of-name clear.
  always_comb begin
    sub_found_n = sub_found_q;
    sub_start_n = sub_start_q;
    prog_n      = prog_q;
    run_n       = run_q;
    pos_n       = pos_q;
    if (!take) begin
      pos_n = PW'(fnms_pkg::MAX_NAME_LEN + 1);
    end else begin
      pos_n = pos_plus1[PW-1:0];
      if (!sub_found_q) begin
        if (pattern_i.len == '0) begin
          sub_found_n = 1'b1;
          sub_start_n = '0;
        end else if (window_full && window_eq) begin
          sub_found_n = 1'b1;
          sub_start_n = pos_plus1[PW-1:0] - PW'(pattern_i.len);
        end
      end
      if (char_match) begin
        run_n  = run_q + SW'(add);
        prog_n = prog_q + LW'(1);
      end
    end
  end

  assign pen_prod = pos_n * fnms_pkg::DIV10_MUL;
  assign pen      = SW'(pen_prod >> fnms_pkg::DIV10_SHIFT);

  always_comb begin
    score = '0;
    if (pos_n > PW'(fnms_pkg::MAX_NAME_LEN)) begin
      score = '0;
    end else if (sub_found_n) begin
      if (SW'(sub_start_n) < fnms_pkg::SCORE_SUBSTRING) begin
        score = fnms_pkg::SCORE_SUBSTRING - SW'(sub_start_n);
      end
    end else if (prog_n >= pattern_i.len) begin
      score = (run_n > pen) ? run_n - pen : '0;
      if (score == '0) begin
        score = SW'(1);
      end
    end
  end

  assign result_o.match_score   = score;
  assign result_o.name_too_long = pos_n > PW'(fnms_pkg::MAX_NAME_LEN);

  always_comb begin
    recent_d     = recent_q;
    prev_raw_d   = prev_raw_q;
    prev_match_d = prev_match_q;
    if (take) begin
      recent_d     = window;
      prev_raw_d   = raw;
      prev_match_d = char_match;
    end
    pos_d       = pos_n;
    prog_d      = prog_n;
    run_d       = run_n;
    sub_found_d = sub_found_n;
    sub_start_d = sub_start_n;
    // Every name starts from a clean state.
    if (item_i.last_char) begin
      recent_d     = '0;
      prev_raw_d   = '0;
      prev_match_d = 1'b0;
      pos_d        = '0;
      prog_d       = '0;
      run_d        = '0;
      sub_found_d  = 1'b0;
      sub_start_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q     <= '0;
      prev_raw_q   <= '0;
      pos_q        <= '0;
      prog_q       <= '0;
      prev_match_q <= 1'b0;
      run_q        <= '0;
      sub_found_q  <= 1'b0;
      sub_start_q  <= '0;
    end else if (step_i) begin
      recent_q     <= recent_d;
      prev_raw_q   <= prev_raw_d;
      pos_q        <= pos_d;
      prog_q       <= prog_d;
      prev_match_q <= prev_match_d;
      run_q        <= run_d;
      sub_found_q  <= sub_found_d;
      sub_start_q  <= sub_start_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fnms_checker.sv =====
// ----------------------------------------------------------------------------
// fnms_checker
// Port-level checks for the file name match scorer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fnms_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_ready_o,
  input wire                       out_valid_o,
  input wire                       out_ready_i,
  input wire fnms_pkg::out_item_t  out_data_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // With the output slot empty nothing can block the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // An overlong name never carries a score.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.name_too_long |-> out_data_o.match_score == '0)
    else $error("score on overlong name");

  // Scores never exceed the substring maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.match_score <= fnms_pkg::SCORE_SUBSTRING)
    else $error("score out of range");

endmodule

bind fuzzy_name_match_scorer_top fnms_checker u_fnms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== tb/sv/fuzzy_name_match_scorer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_name_match_scorer_top_test
// Streams file names byte by byte through the scorer under random flow control
// on both sides. A shadow of the scoring rules predicts the score and the
// too-long flag of every name, and each result request is checked against it.
// ----------------------------------------------------------------------------

module fuzzy_name_match_scorer_top_test;

  typedef logic [7:0] name_t[$];

  typedef enum int {
    NAME_SUBSTRING,
    NAME_SUBSEQ,
    NAME_BROKEN,
    NAME_NOISE,
    NAME_LONG
  } name_kind_e;

  localparam logic [fnms_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [7:0] SLASH     = 8'h2F;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam int RANDOM_BYTES = 80;
  localparam int HOLD_CYCLES  = 150;
  localparam int STUCK_LIMIT  = 3000;
  localparam int MAX_GAP      = 20;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  fnms_pkg::in_item_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  fnms_pkg::out_item_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [fnms_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [fnms_pkg::CFG_DATA_W-1:0] cfg_data_i;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int error_count;
  int bytes_sent;
  fnms_pkg::out_item_t expected_results[$];

  // Shadow of the pattern registers and of the per-name scoring state.
  logic [63:0] pat_low_m;
  logic [63:0] pat_high_m;
  logic [4:0] pat_len_m;
  logic [7:0] recent_m[16];
  logic [7:0] prev_raw_m;
  int unsigned pos_m;
  int unsigned progress_m;
  int unsigned sub_start_m;
  bit prev_hit_m;
  bit sub_found_m;
  logic [9:0] running_m;

  // Pattern as last loaded, used to build names that hit it.
  logic [7:0] cur_pat[16];
  int cur_len;

  fuzzy_name_match_scorer_top uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_upper_c(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic bit is_lower_c(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return is_upper_c(c) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return is_lower_c(c) ? c - 8'd32 : c;
  endfunction

  function automatic int unsigned pattern_span();
    return (pat_len_m > fnms_pkg::MAX_PATTERN_LEN) ? fnms_pkg::MAX_PATTERN_LEN : pat_len_m;
  endfunction

  function automatic logic [7:0] pattern_char(int unsigned k);
    logic [63:0] w;
    w = (k < 8) ? pat_low_m : pat_high_m;
    return to_lower(w[8*(k%8) +: 8]);
  endfunction

  function automatic void clear_name_state();
    int k;
    for (k = 0; k < 16; k++) recent_m[k] = 8'h00;
    prev_raw_m  = 8'h00;
    pos_m       = 0;
    progress_m  = 0;
    prev_hit_m  = 1'b0;
    running_m   = '0;
    sub_found_m = 1'b0;
    sub_start_m = 0;
  endfunction

  function automatic void take_name_byte(logic [7:0] raw);
    int unsigned span;
    int unsigned pos;
    int unsigned add;
    logic [7:0] low;
    bit same;
    int k;
    span = pattern_span();
    pos  = pos_m;
    low  = to_lower(raw);
    for (k = 15; k > 0; k--) recent_m[k] = recent_m[k-1];
    recent_m[0] = low;

    if (!sub_found_m) begin
      if (span == 0) begin
        sub_found_m = 1'b1;
        sub_start_m = 0;
      end else if (pos + 1 >= span) begin
        same = 1'b1;
        for (k = 0; k < span; k++) begin
          if (recent_m[k] != pattern_char(span - 1 - k)) same = 1'b0;
        end
        if (same) begin
          sub_found_m = 1'b1;
          sub_start_m = pos + 1 - span;
        end
      end
    end

    if (progress_m < span && low == pattern_char(progress_m)) begin
      add = 10;
      // The byte before the first one counts as matched.
      if (pos == 0 || prev_hit_m) add += 5;
      if (pos > 0 && (prev_raw_m == SLASH || prev_raw_m == BACKSLASH ||
                      (is_upper_c(raw) && is_lower_c(prev_raw_m)))) add += 15;
      running_m  = 10'(running_m + add);
      progress_m = progress_m + 1;
      prev_hit_m = 1'b1;
    end else begin
      prev_hit_m = 1'b0;
    end
    prev_raw_m = raw;
    pos_m      = pos + 1;
  endfunction

  function automatic bit predict_score(input fnms_pkg::in_item_t item,
                                       output fnms_pkg::out_item_t res);
    int unsigned pen;
    int unsigned sc;
    res = '0;
    if (pos_m >= fnms_pkg::MAX_NAME_LEN) pos_m = fnms_pkg::MAX_NAME_LEN + 1;
    else take_name_byte(item.name_char);
    if (!item.last_char) return 1'b0;

    if (pos_m > fnms_pkg::MAX_NAME_LEN) begin
      res.name_too_long = 1'b1;
    end else if (sub_found_m) begin
      res.match_score = (sub_start_m >= 1000) ? 10'd0 : 10'(1000 - sub_start_m);
    end else if (progress_m >= pattern_span()) begin
      pen = pos_m / 10;
      sc  = (running_m > pen) ? running_m - pen : 0;
      if (sc < 1) sc = 1;
      res.match_score = 10'(sc);
    end
    clear_name_state();
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_filler();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'(8'h61 + $urandom_range(25));
    if (r < 85) return 8'(8'h41 + $urandom_range(25));
    if (r < 95) return 8'(8'h30 + $urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] vary_case(logic [7:0] c);
    if ((is_upper_c(c) || is_lower_c(c)) && $urandom_range(1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  function automatic name_t text_name(string s);
    name_t n;
    int k;
    n = {};
    for (k = 0; k < s.len(); k++) n.push_back(s[k]);
    return n;
  endfunction

  function automatic name_kind_e pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 30) return NAME_SUBSTRING;
    if (r < 65) return NAME_SUBSEQ;
    if (r < 80) return NAME_BROKEN;
    if (r < 99) return NAME_NOISE;
    return NAME_LONG;
  endfunction

  function automatic name_t make_name(name_kind_e kind);
    name_t n;
    int span;
    int skip;
    int k;
    int j;
    n = {};
    span = (cur_len > fnms_pkg::MAX_PATTERN_LEN) ? fnms_pkg::MAX_PATTERN_LEN : cur_len;
    case (kind)
      NAME_NOISE: begin
        repeat ($urandom_range(16, 1)) n.push_back(8'($urandom_range(255)));
      end
      NAME_LONG: begin
        // The pattern lands near the length bound, on either side of it.
        repeat ($urandom_range(300, fnms_pkg::MAX_NAME_LEN - 20)) n.push_back(rand_filler());
        for (k = 0; k < span; k++) n.push_back(vary_case(cur_pat[k]));
      end
      NAME_SUBSTRING: begin
        repeat ($urandom_range(8, 0)) n.push_back(rand_filler());
        for (k = 0; k < span; k++) n.push_back(vary_case(cur_pat[k]));
        repeat ($urandom_range(5, 0)) n.push_back(rand_filler());
      end
      default: begin
        // A broken name drops one pattern character so the match stays short.
        skip = (kind == NAME_BROKEN && span > 0) ? $urandom_range(span - 1, 0) : -1;
        for (k = 0; k < span; k++) begin
          if (k == skip) continue;
          repeat ($urandom_range(3, 0)) n.push_back(rand_filler());
          j = $urandom_range(5, 0);
          if (j == 0) n.push_back(SLASH);
          else if (j == 1) n.push_back(BACKSLASH);
          else if (j == 2) n.push_back(8'(8'h61 + $urandom_range(25)));
          n.push_back((j == 2) ? to_upper(cur_pat[k]) : vary_case(cur_pat[k]));
        end
        repeat ($urandom_range(4, 0)) n.push_back(rand_filler());
      end
    endcase
    if (n.size() == 0) n.push_back(rand_filler());
    return n;
  endfunction

  task automatic send_byte(logic [7:0] ch, bit last);
    fnms_pkg::in_item_t item;
    fnms_pkg::out_item_t res;
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.last_char = last;
    item.name_char = ch;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    if (predict_score(item, res)) expected_results.push_back(res);
  endtask

  task automatic send_name(name_t n);
    int k;
    for (k = 0; k < n.size(); k++) send_byte(n[k], k == n.size() - 1);
  endtask

  // Waits until every score is back and the block holds no name.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after its last write.
  task automatic write_reg(logic [fnms_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      fnms_pkg::CFG_PAT_LOW:  pat_low_m = value;
      fnms_pkg::CFG_PAT_HIGH: pat_high_m = value;
      fnms_pkg::CFG_PAT_LEN:  pat_len_m = value[4:0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(input logic [7:0] chars[16], input int len);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    int k;
    for (k = 0; k < 8; k++) begin
      lo[8*k +: 8] = chars[k];
      hi[8*k +: 8] = chars[k+8];
    end
    // Only the low five bits of the length word are meaningful.
    len_word = {$urandom, $urandom};
    len_word[4:0] = len[4:0];
    cur_pat = chars;
    cur_len = len;
    settle();
    write_reg(fnms_pkg::CFG_PAT_LOW, lo);
    write_reg(fnms_pkg::CFG_PAT_HIGH, hi);
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    write_reg(fnms_pkg::CFG_PAT_LEN, len_word);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_text_pattern(string s, int len);
    logic [7:0] chars[16];
    int k;
    for (k = 0; k < 16; k++) chars[k] = (k < s.len()) ? s[k] : 8'($urandom_range(255));
    load_pattern(chars, len);
  endtask

  task automatic random_pattern();
    logic [7:0] chars[16];
    int k;
    int len;
    int r;
    r = $urandom_range(99);
    if (r < 5) len = 0;
    else if (r < 70) len = $urandom_range(6, 1);
    else if (r < 90) len = $urandom_range(16, 7);
    else len = $urandom_range(31, 17);
    for (k = 0; k < 16; k++) begin
      chars[k] = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : rand_filler();
    end
    load_pattern(chars, len);
  endtask

  task automatic test_empty_pattern();
    // Straight out of reset the pattern is empty, so every name scores 1000.
    send_name(text_name("Ab"));
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    load_text_pattern("zzz", 0);
    send_name(text_name("q"));
  endtask

  task automatic test_unknown_index();
    load_text_pattern("xy", 2);
    settle();
    write_reg(CFG_UNUSED, '1);
    write_reg(CFG_UNUSED, '0);
    cfg_valid_i <= 1'b0;
    send_name(text_name("aXy"));
  endtask

  task automatic test_match_bonuses();
    load_text_pattern("abc", 3);
    send_name(text_name("abc"));
    send_name(text_name("xxABc"));
    send_name(text_name("aXbYc"));
    send_name(text_name("x/ab\\c"));
    send_name(text_name("xAyBzC"));
    send_name(text_name("ab"));
    send_name(text_name("acb"));
  endtask

  task automatic test_pattern_extremes();
    name_t n;
    n = {};
    load_text_pattern("\xff\xff\xff\xff\xff\xff\xff\xff\xff\xff\xff\xff\xff\xff\xff\xff", 16);
    repeat (16) n.push_back(8'hFF);
    send_name(n);
    // Length 31 counts as the full sixteen characters.
    load_text_pattern("ABCDEFGHIJKLMNOP", 31);
    send_name(text_name("xabcdefghijklmnop"));
    load_text_pattern("ABCDEFGHIJKLMNOP", 17);
    send_name(text_name("abcdefghijklmno"));
  endtask

  task automatic test_non_ascii();
    name_t n;
    load_text_pattern("\xc1\xe9", 2);
    n = {8'hC1, 8'hE9};
    send_name(n);
    n = {8'hE1, 8'hC9};
    send_name(n);
    n = {8'hC1, "x", 8'hE9};
    send_name(n);
  endtask

  task automatic test_long_names();
    name_t n;
    load_text_pattern("qz", 2);
    n = {};
    repeat (fnms_pkg::MAX_NAME_LEN - 2) n.push_back("m");
    n.push_back("Q");
    n.push_back("z");
    send_name(n);
    n.push_back("x");
    send_name(n);
    repeat (3) n.push_back("q");
    send_name(n);
    // Scattered match in a long name: the length penalty drives it to the floor.
    n = {};
    repeat (240) n.push_back("m");
    n[10]  = "q";
    n[200] = "z";
    send_name(n);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_text_pattern("ab", 2);
    hold_req++;
    repeat (16) send_name(make_name(($urandom_range(1) == 1) ? NAME_SUBSTRING : NAME_NOISE));
    settle();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct);
    int start;
    int names_left;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    names_left = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (names_left == 0) begin
        random_pattern();
        names_left = $urandom_range(12, 4);
      end
      send_name(make_name(pick_kind()));
      names_left--;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    fnms_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no name pending: match_score %0d name_too_long %0b",
               out_data_o.match_score, out_data_o.name_too_long);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.match_score !== want.match_score) begin
          $error("match_score expected %0d actual %0d",
                 want.match_score, out_data_o.match_score);
          error_count++;
        end
        if (out_data_o.name_too_long !== want.name_too_long) begin
          $error("name_too_long expected %0b actual %0b",
                 want.name_too_long, out_data_o.name_too_long);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) stuck = 0;
      else stuck++;
    end
    $display("fuzzy_name_match_scorer_top_test: FAIL");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pat_low_m  = '0;
    pat_high_m = '0;
    pat_len_m  = '0;
    cur_len    = 0;
    clear_name_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_pattern();
    test_unknown_index();
    test_match_bonuses();
    test_pattern_extremes();
    test_non_ascii();
    test_long_names();
    test_backpressure();
    test_random_traffic(22, 65);
    test_random_traffic(65, 22);
    test_random_traffic(0, 0);

    settle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("fuzzy_name_match_scorer_top_test: PASS");
    end else begin
      $display("fuzzy_name_match_scorer_top_test: FAIL");
    end
    $finish;
  end

endmodule
